>>> design/fbmp_pkg.sv
// fbmp_pkg: shared widths, types, the square-root step and the tangent table
// for the FFT bin magnitude/phase pipeline. No dependencies.
package fbmp_pkg;

    localparam int IN_W        = 16;
    localparam int MAG_W       = 17;
    localparam int PH_W        = 9;
    localparam int DEG_W       = 7;
    localparam int N_W         = 34;
    localparam int REM_W       = 21;
    localparam int TAN_FRAC    = 52;
    localparam int TAN_W       = TAN_FRAC + 1;
    localparam int PROD_W      = IN_W + TAN_W;
    localparam int MAG_STAGES  = 6;
    localparam int STEP_PER_ST = 3;
    localparam int SQRT_STEPS  = 17;
    localparam int PH_STAGES   = 7;
    localparam int PIPE_DEPTH  = 8;
    localparam int DEG_MAX     = 89;
    localparam int DEG_HALF    = 45;
    localparam int DEG_QUAD    = 90;

    localparam real PI        = 3.14159265358979323846;
    localparam real TAN_SCALE = 2.0 ** TAN_FRAC;

    typedef logic [IN_W-1:0]  uval_t;
    typedef logic [DEG_W-1:0] deg_t;
    typedef logic [1:0]       quad_t;
    typedef logic [TAN_W-1:0] tan_t;
    typedef tan_t tan_tbl_t [0:DEG_HALF];

    typedef struct packed {
        logic [N_W-1:0]   rad;
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
    } sqrt_state_t;

    typedef struct packed {
        uval_t u;
        uval_t v;
        quad_t q;
        logic  zero;
    } ph_item_t;

    function automatic tan_tbl_t make_tan_tbl();
        tan_tbl_t t;
        real r;
        for (int d = 0; d <= DEG_HALF; d++)
        begin
            r = $tan(real'(d) * PI / 180.0) * TAN_SCALE;
            t[d] = tan_t'(longint'(r));
        end
        return t;
    endfunction

    localparam tan_tbl_t TAN_TBL = make_tan_tbl();

    function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
        sqrt_state_t r;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        rem2  = {s.rem[REM_W-3:0], s.rad[N_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        r.rad = {s.rad[N_W-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            r.rem  = rem2 - trial;
            r.root = {s.root[MAG_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2;
            r.root = {s.root[MAG_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> design/fbmp_in_if.sv
// fbmp_in_if: input bin channel (valid/ready plus real, imaginary, DC flag).
// Uses fbmp_pkg for field widths.
interface fbmp_in_if;
    logic                       valid;
    logic                       ready;
    logic signed [fbmp_pkg::IN_W-1:0] real_part;
    logic signed [fbmp_pkg::IN_W-1:0] imag_part;
    logic                       dc_bin;

    modport source (output valid, output real_part, output imag_part, output dc_bin,
                    input ready);
    modport sink   (input valid, input real_part, input imag_part, input dc_bin,
                    output ready);
endinterface

>>> design/fbmp_out_if.sv
// fbmp_out_if: result channel (valid/ready plus magnitude and phase).
// Uses fbmp_pkg for field widths.
interface fbmp_out_if;
    logic                        valid;
    logic                        ready;
    logic [fbmp_pkg::MAG_W-1:0]  magnitude;
    logic [fbmp_pkg::PH_W-1:0]   phase_degrees;

    modport source (output valid, output magnitude, output phase_degrees, input ready);
    modport sink   (input valid, input magnitude, input phase_degrees, output ready);
endinterface

>>> design/fbmp_mag_pipe.sv
// fbmp_mag_pipe: power stage then digit-by-digit square root, three digits
// per stage over six stages (two in the last). Depends on fbmp_pkg.
module fbmp_mag_pipe (
    input  logic                       clk,
    input  logic                       en,
    input  fbmp_pkg::uval_t            ax,
    input  fbmp_pkg::uval_t            ay,
    input  logic                       dc,
    output logic [fbmp_pkg::MAG_W-1:0] magnitude
);
    logic [fbmp_pkg::N_W-1:0] n_reg, n_next;
    fbmp_pkg::sqrt_state_t    st_reg  [fbmp_pkg::MAG_STAGES];
    fbmp_pkg::sqrt_state_t    st_next [fbmp_pkg::MAG_STAGES];
    logic [31:0] pw;

    always_comb
    begin
        pw = 32'(ax) * 32'(ax) + 32'(ay) * 32'(ay);
        n_next = dc ? {2'b00, pw} : {pw, 2'b00};
    end

    always_comb
    begin
        fbmp_pkg::sqrt_state_t s;
        for (int j = 0; j < fbmp_pkg::MAG_STAGES; j++)
        begin
            if (j == 0)
            begin
                s.rad  = n_reg;
                s.rem  = '0;
                s.root = '0;
            end
            else
            begin
                s = st_reg[j-1];
            end
            for (int k = 0; k < fbmp_pkg::STEP_PER_ST; k++)
            begin
                if (j * fbmp_pkg::STEP_PER_ST + k < fbmp_pkg::SQRT_STEPS)
                    s = fbmp_pkg::sqrt_step(s);
            end
            st_next[j] = s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg  <= n_next;
            st_reg <= st_next;
        end
    end

    assign magnitude = st_reg[fbmp_pkg::MAG_STAGES-1].root;
endmodule

>>> design/fbmp_phase_pipe.sv
// fbmp_phase_pipe: seven-stage binary search for the whole-degree angle in
// the first quadrant, one tangent compare per stage. Depends on fbmp_pkg.
module fbmp_phase_pipe (
    input  logic                      clk,
    input  logic                      en,
    input  fbmp_pkg::ph_item_t        item,
    output logic [fbmp_pkg::PH_W-1:0] phase_degrees
);
    fbmp_pkg::ph_item_t it_reg  [fbmp_pkg::PH_STAGES];
    fbmp_pkg::deg_t     lo_reg  [fbmp_pkg::PH_STAGES];
    fbmp_pkg::deg_t     hi_reg  [fbmp_pkg::PH_STAGES];
    fbmp_pkg::deg_t     lo_next [fbmp_pkg::PH_STAGES];
    fbmp_pkg::deg_t     hi_next [fbmp_pkg::PH_STAGES];
    fbmp_pkg::ph_item_t it_next [fbmp_pkg::PH_STAGES];

    always_comb
    begin
        fbmp_pkg::ph_item_t it;
        fbmp_pkg::deg_t lo, hi, mid;
        logic [7:0] sum;
        logic [5:0] idx;
        logic below;
        logic pass;
        fbmp_pkg::uval_t a, b;
        logic [fbmp_pkg::PROD_W-1:0] prod, other;
        for (int j = 0; j < fbmp_pkg::PH_STAGES; j++)
        begin
            if (j == 0)
            begin
                it = item;
                lo = '0;
                hi = fbmp_pkg::deg_t'(fbmp_pkg::DEG_MAX);
            end
            else
            begin
                it = it_reg[j-1];
                lo = lo_reg[j-1];
                hi = hi_reg[j-1];
            end
            sum   = 8'(lo) + 8'(hi) + 8'd1;
            mid   = sum[7:1];
            below = mid < fbmp_pkg::deg_t'(fbmp_pkg::DEG_HALF);
            idx   = below ? mid[5:0] : 6'(7'(fbmp_pkg::DEG_QUAD) - mid);
            a     = below ? it.u : it.v;
            b     = below ? it.v : it.u;
            prod  = fbmp_pkg::PROD_W'(a) * fbmp_pkg::PROD_W'(fbmp_pkg::TAN_TBL[idx]);
            other = fbmp_pkg::PROD_W'({b, {fbmp_pkg::TAN_FRAC{1'b0}}});
            priority if (mid == fbmp_pkg::deg_t'(fbmp_pkg::DEG_HALF))
                pass = it.v >= it.u;
            else if (below)
                pass = other >= prod;
            else
                pass = prod >= other;
            if (lo < hi)
            begin
                if (pass)
                    lo = mid;
                else
                    hi = mid - 7'd1;
            end
            it_next[j] = it;
            lo_next[j] = lo;
            hi_next[j] = hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg <= it_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_comb
    begin
        fbmp_pkg::ph_item_t last;
        last = it_reg[fbmp_pkg::PH_STAGES-1];
        if (last.zero)
            phase_degrees = '0;
        else
            phase_degrees = 9'(last.q) * 9'(fbmp_pkg::DEG_QUAD)
                          + 9'(lo_reg[fbmp_pkg::PH_STAGES-1]);
    end
endmodule

>>> design/fft_bin_magnitude_phase_top.sv
// fft_bin_magnitude_phase_top: input prep stage, valid pipeline and stall
// control around fbmp_mag_pipe and fbmp_phase_pipe. Depends on fbmp_pkg.
//
//  channel  modport  fields                               transfer
//  bin      sink     real_part, imag_part, dc_bin         valid && ready
//  result   source   magnitude, phase_degrees             valid && ready
//
// One bin per cycle sustained while the result is not stalled; depth set by the
// 17-digit square root and the 7-step degree search.
// rst_n clears only the valid bits; data registers carry no reset.
// A stalled result freezes the whole pipeline; bin.ready = !result.valid
// || result.ready.
module fft_bin_magnitude_phase_top (
    input  logic         clk,
    input  logic         rst_n,
    fbmp_in_if.sink      bin,
    fbmp_out_if.source   result
);
    logic [fbmp_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic en;
    fbmp_pkg::uval_t ax_reg, ay_reg, ax_next, ay_next;
    logic dc_reg;
    fbmp_pkg::ph_item_t ph_reg, ph_next;

    assign en = !valid_reg[fbmp_pkg::PIPE_DEPTH-1] || result.ready;
    assign bin.ready = en;

    always_comb
    begin
        ax_next = bin.real_part[fbmp_pkg::IN_W-1] ? fbmp_pkg::uval_t'(-bin.real_part)
                                                  : fbmp_pkg::uval_t'(bin.real_part);
        ay_next = bin.imag_part[fbmp_pkg::IN_W-1] ? fbmp_pkg::uval_t'(-bin.imag_part)
                                                  : fbmp_pkg::uval_t'(bin.imag_part);
        ph_next.zero = (bin.real_part == '0) && (bin.imag_part == '0);
        priority if (!bin.imag_part[fbmp_pkg::IN_W-1] && bin.real_part > 0)
        begin
            ph_next.q = 2'd0;
            ph_next.u = ax_next;
            ph_next.v = ay_next;
        end
        else if (bin.real_part <= 0 && bin.imag_part > 0)
        begin
            ph_next.q = 2'd1;
            ph_next.u = ay_next;
            ph_next.v = ax_next;
        end
        else if (bin.imag_part <= 0 && bin.real_part[fbmp_pkg::IN_W-1])
        begin
            ph_next.q = 2'd2;
            ph_next.u = ax_next;
            ph_next.v = ay_next;
        end
        else
        begin
            ph_next.q = 2'd3;
            ph_next.u = ay_next;
            ph_next.v = ax_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[fbmp_pkg::PIPE_DEPTH-2:0], bin.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            dc_reg <= bin.dc_bin;
            ph_reg <= ph_next;
        end
    end

    fbmp_mag_pipe u_mag (
        .clk       (clk),
        .en        (en),
        .ax        (ax_reg),
        .ay        (ay_reg),
        .dc        (dc_reg),
        .magnitude (result.magnitude)
    );

    fbmp_phase_pipe u_phase (
        .clk           (clk),
        .en            (en),
        .item          (ph_reg),
        .phase_degrees (result.phase_degrees)
    );

    assign result.valid = valid_reg[fbmp_pkg::PIPE_DEPTH-1];

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        bin.ready == (!result.valid || result.ready))
        else $error("ready does not follow output stall");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.phase_degrees < 9'd360)
        else $error("phase out of range");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.magnitude <= 17'd92682)
        else $error("magnitude out of range");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(valid_reg))
        else $error("pipeline moved during stall");
endmodule

>>> sim/fbmp_result_checker.sv
// fbmp_result_checker: watches the bin and result channels, predicts magnitude and
// phase for each accepted bin and compares the results in order.
// Depends on fbmp_pkg, fbmp_in_if and fbmp_out_if.
module fbmp_result_checker (
    input  logic   clk,
    input  logic   rst_n,
    fbmp_in_if     bin,
    fbmp_out_if    result,
    output int     fail_count,
    output int     pending
);
    localparam longint unsigned PI_FIX  = 64'hC90FDAA22168C234;
    localparam longint unsigned ONE_FIX = 64'h4000000000000000;

    typedef struct {
        logic [fbmp_pkg::MAG_W-1:0] mag;
        logic [fbmp_pkg::PH_W-1:0]  ph;
    } polar_t;

    polar_t polar_q[$];

    function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic void sin_cos(int d, output longint unsigned s,
                                    output longint unsigned c);
        longint unsigned x, x2, ts, tc;
        x  = (PI_FIX / 180) * d + ((PI_FIX % 180) * d) / 180;
        x2 = fix_mul(x, x);
        ts = x;
        tc = ONE_FIX;
        s  = x;
        c  = ONE_FIX;
        for (int k = 1; k <= 12; k++)
        begin
            ts = fix_mul(ts, x2) / longint'((2 * k) * (2 * k + 1));
            tc = fix_mul(tc, x2) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
            begin
                s = s - ts;
                c = c - tc;
            end
            else
            begin
                s = s + ts;
                c = c + tc;
            end
        end
    endfunction

    function automatic bit reaches_deg(longint unsigned u, longint unsigned v, int d);
        longint unsigned s, c;
        logic [127:0] lhs, rhs;
        if (d == 0)
            return 1'b1;
        if (d == fbmp_pkg::DEG_HALF)
            return v >= u;
        if (d < fbmp_pkg::DEG_HALF)
            sin_cos(d, s, c);
        else
            sin_cos(fbmp_pkg::DEG_QUAD - d, c, s);
        lhs = {64'd0, v} * {64'd0, c};
        rhs = {64'd0, u} * {64'd0, s};
        return lhs >= rhs;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic polar_t bin_to_polar(logic signed [fbmp_pkg::IN_W-1:0] re,
                                            logic signed [fbmp_pkg::IN_W-1:0] im,
                                            logic dc);
        polar_t p;
        longint x, y;
        longint unsigned pw, u, v;
        int q, lo, hi, mid;
        x  = re;
        y  = im;
        pw = longint'(x * x + y * y);
        p.mag = fbmp_pkg::MAG_W'(int_sqrt(dc ? pw : 4 * pw));
        p.ph  = '0;
        if (x != 0 || y != 0)
        begin
            if (y >= 0 && x > 0)
            begin
                q = 0; u = x;  v = y;
            end
            else if (x <= 0 && y > 0)
            begin
                q = 1; u = y;  v = -x;
            end
            else if (y <= 0 && x < 0)
            begin
                q = 2; u = -x; v = -y;
            end
            else
            begin
                q = 3; u = -y; v = x;
            end
            lo = 0;
            hi = fbmp_pkg::DEG_MAX;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                if (reaches_deg(u, v, mid))
                    lo = mid;
                else
                    hi = mid - 1;
            end
            p.ph = fbmp_pkg::PH_W'(q * fbmp_pkg::DEG_QUAD + lo);
        end
        return p;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial
        fail_count = 0;

    assign pending = polar_q.size();

    always @(posedge clk)
    begin
        polar_t want;
        if (rst_n)
        begin
            if (bin.valid && bin.ready)
                polar_q.push_back(bin_to_polar(bin.real_part, bin.imag_part, bin.dc_bin));
            if (result.valid && result.ready)
            begin
                if (polar_q.size() == 0)
                    report("unexpected transfer", int'(result.magnitude), -1);
                else
                begin
                    want = polar_q.pop_front();
                    if (result.magnitude !== want.mag)
                        report("magnitude", int'(result.magnitude), int'(want.mag));
                    if (result.phase_degrees !== want.ph)
                        report("phase_degrees", int'(result.phase_degrees), int'(want.ph));
                end
            end
        end
    end
endmodule

>>> sim/tb_fft_bin_magnitude_phase_top.sv
// tb_fft_bin_magnitude_phase_top: drives bins into the magnitude/phase block under
// several idle and stall mixes and gives the verdict. Depends on fbmp_pkg,
// the channel interfaces, the block and fbmp_result_checker.
module tb_fft_bin_magnitude_phase_top;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   quiet_cycles;

    fbmp_in_if  bin ();
    fbmp_out_if result ();

    fft_bin_magnitude_phase_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bin    (bin),
        .result (result)
    );

    fbmp_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .bin        (bin),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        result.ready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        if ((bin.valid && bin.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL fft_bin_magnitude_phase_top");
            $finish;
        end
    end

    task automatic send_bin(int re, int im, bit dc);
        while ($urandom_range(99) < src_idle_pct)
        begin
            bin.valid <= 1'b0;
            @(posedge clk);
        end
        bin.valid     <= 1'b1;
        bin.real_part <= fbmp_pkg::IN_W'(re);
        bin.imag_part <= fbmp_pkg::IN_W'(im);
        bin.dc_bin    <= dc;
        @(posedge clk);
        while (!bin.ready)
            @(posedge clk);
    endtask

    task automatic send_random_bin();
        int re, im, m;
        re = $urandom_range(65535) - 32768;
        im = $urandom_range(65535) - 32768;
        case ($urandom_range(5))
            0: im = 0;
            1: re = 0;
            2: im = ($urandom_range(1) ? re : -re);
            3:
            begin
                m  = $urandom_range(200);
                re = $urandom_range(2 * m) - m;
                im = $urandom_range(2 * m) - m;
            end
            default: ;
        endcase
        if (im > 32767) im = 32767;
        if (im < -32768) im = -32768;
        send_bin(re, im, $urandom_range(1));
    endtask

    initial
    begin
        rst_n            = 1'b0;
        bin.valid        = 1'b0;
        bin.real_part    = '0;
        bin.imag_part    = '0;
        bin.dc_bin       = 1'b0;
        result.ready     = 1'b0;
        src_idle_pct     = 0;
        snk_stall_pct    = 0;
        quiet_cycles     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_bin(0, 0, 0);
        send_bin(0, 0, 1);
        send_bin(32767, 0, 0);
        send_bin(0, 32767, 0);
        send_bin(-32768, 0, 0);
        send_bin(0, -32768, 0);
        send_bin(-32768, -32768, 0);
        send_bin(-32768, -32768, 1);
        send_bin(32767, 32767, 0);
        send_bin(-32768, 32767, 1);
        send_bin(32767, -32768, 0);
        send_bin(1000, 1000, 0);
        send_bin(-1000, 1000, 0);
        send_bin(-1000, -1000, 1);
        send_bin(1000, -1000, 0);
        send_bin(1, 0, 1);
        send_bin(0, -1, 0);
        send_bin(-1, 1, 0);
        send_bin(32767, 1, 0);
        send_bin(1, -32768, 1);

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 56 : 38) : 0;
            snk_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 56 : 38) : 0;
            for (int i = 0; i < 135; i++)
                send_random_bin();
        end
        bin.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS fft_bin_magnitude_phase_top");
        else
            $display("FAIL fft_bin_magnitude_phase_top");
        $finish;
    end
endmodule

>>> sim.f
design/fbmp_pkg.sv
design/fbmp_in_if.sv
design/fbmp_out_if.sv
design/fbmp_mag_pipe.sv
design/fbmp_phase_pipe.sv
design/fft_bin_magnitude_phase_top.sv
sim/fbmp_result_checker.sv
sim/tb_fft_bin_magnitude_phase_top.sv
